### rtl/brsp_pkg.sv
// Shared types, constants and arithmetic helpers of the regularised Bingham stress point.
`default_nettype none
package brsp_pkg;

	localparam int NLANE = 6;

	// flow mode codes (the fourth code behaves as spatial flow)
	localparam logic [1:0] MODE_PLANE  = 2'd0;
	localparam logic [1:0] MODE_AXISYM = 2'd1;

	// configuration register indexes
	localparam logic [1:0] REG_BASE_VISC = 2'd0;
	localparam logic [1:0] REG_YIELD     = 2'd1;
	localparam logic [1:0] REG_GROWTH    = 2'd2;

	localparam logic [30:0] MAX31     = 31'h7fff_ffff;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	// partial remainder and root of the digit-by-digit square root
	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sqrt_acc_t;

	// one root bit of the square root, from the next pair of radicand bits
	function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t a, input logic [1:0] pair);
		logic [35:0] t;
		logic [35:0] trial;
		sqrt_acc_t   r;
		t     = {a.rem, pair};
		trial = {2'b00, a.root, 2'b01};
		if (t >= trial) begin
			r.rem  = 34'(t - trial);
			r.root = {a.root[30:0], 1'b1};
		end else begin
			r.rem  = t[33:0];
			r.root = {a.root[30:0], 1'b0};
		end
		return r;
	endfunction

	// floor square root, used for elaboration-time tables
	function automatic logic [31:0] isqrt64(input logic [63:0] v);
		sqrt_acc_t   a;
		logic [63:0] w;
		a = '0;
		w = v;
		for (int i = 0; i < 32; i++) begin
			a = sqrt_step(a, w[63:62]);
			w = {w[61:0], 2'b00};
		end
		return a.root;
	endfunction

	// factor 2^(-2^-j) in Q2.30, built by repeated square roots
	function automatic logic [31:0] exp_coeff(input int j);
		logic [31:0] t;
		t = isqrt64(64'd1 << 59);
		for (int i = 1; i < j; i++)
			t = isqrt64({2'b00, t, 30'b0});
		return t;
	endfunction

	// magnitude of a two's complement word, 0 .. 2^31
	function automatic logic [31:0] mag32(input logic [31:0] r);
		return r[31] ? 32'(-r) : r;
	endfunction

endpackage
`default_nettype wire

### rtl/brsp_sqrt.sv
// Pipelined floor square root of a 64-bit value, two digits per stage.
`default_nettype none
module brsp_sqrt import brsp_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int PER = 2;
	localparam int NST = 32 / PER;

	logic              vld_s  [NST];
	sqrt_acc_t         acc_s  [NST];
	logic [63:0]       rad_s  [NST];
	logic [SIDE_W-1:0] side_s [NST];

	genvar k;
	generate
		for (k = 0; k < NST; k++) begin : g_st
			logic              pv;
			sqrt_acc_t         pa;
			logic [63:0]       pr;
			logic [SIDE_W-1:0] ps;
			sqrt_acc_t         acc_c;
			logic [63:0]       rad_c;

			if (k == 0) begin : g_in
				assign pv = in_valid;
				assign pa = '0;
				assign pr = in_rad;
				assign ps = in_side;
			end else begin : g_prev
				assign pv = vld_s[k-1];
				assign pa = acc_s[k-1];
				assign pr = rad_s[k-1];
				assign ps = side_s[k-1];
			end

			// take two digits of the radicand
			always_comb begin
				acc_c = pa;
				rad_c = pr;
				for (int i = 0; i < PER; i++) begin
					acc_c = sqrt_step(acc_c, rad_c[63:62]);
					rad_c = {rad_c[61:0], 2'b00};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= pv;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k]  <= acc_c;
					rad_s[k]  <= rad_c;
					side_s[k] <= ps;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NST-1];
	assign out_root  = acc_s[NST-1].root;
	assign out_side  = side_s[NST-1];

endmodule
`default_nettype wire

### rtl/brsp_exp.sv
// Pipelined 2^-y in Q2.30: one conditional rounded multiply per fraction bit, then the shift.
`default_nettype none
module brsp_exp import brsp_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic              in_zero,
	input  logic [4:0]        in_shift,
	input  logic [29:0]       in_frac,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [30:0]       out_value,
	output logic [SIDE_W-1:0] out_side
);

	localparam int NJ = 30;
	localparam logic [61:0] HALF = 62'd1 << 29;

	logic              vld_s  [NJ];
	logic [30:0]       acc_s  [NJ];
	logic [29:0]       frac_s [NJ];
	logic [4:0]        sh_s   [NJ];
	logic              zero_s [NJ];
	logic [SIDE_W-1:0] side_s [NJ];

	logic              res_vld_s;
	logic [30:0]       res_val_s;
	logic [SIDE_W-1:0] res_side_s;

	genvar k;
	generate
		for (k = 0; k < NJ; k++) begin : g_st
			localparam logic [30:0] COEF = 31'(exp_coeff(k + 1));
			logic              pv;
			logic [30:0]       pa;
			logic [29:0]       pf;
			logic [4:0]        pn;
			logic              pz;
			logic [SIDE_W-1:0] ps;
			logic [61:0]       prod_c;
			logic [30:0]       acc_c;

			if (k == 0) begin : g_in
				assign pv = in_valid;
				assign pa = ONE_Q30;
				assign pf = in_frac;
				assign pn = in_shift;
				assign pz = in_zero;
				assign ps = in_side;
			end else begin : g_prev
				assign pv = vld_s[k-1];
				assign pa = acc_s[k-1];
				assign pf = frac_s[k-1];
				assign pn = sh_s[k-1];
				assign pz = zero_s[k-1];
				assign ps = side_s[k-1];
			end

			// multiply by the factor of this fraction bit, rounded to nearest
			always_comb begin
				prod_c = {31'b0, pa} * {31'b0, COEF} + HALF;
				acc_c  = pf[NJ-1-k] ? prod_c[60:30] : pa;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= pv;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					acc_s[k]  <= acc_c;
					frac_s[k] <= pf;
					sh_s[k]   <= pn;
					zero_s[k] <= pz;
					side_s[k] <= ps;
				end
			end
		end
	endgenerate

	// apply the integer part as a right shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_vld_s <= 1'b0;
		else if (en)
			res_vld_s <= vld_s[NJ-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_val_s  <= zero_s[NJ-1] ? '0 : (acc_s[NJ-1] >> sh_s[NJ-1]);
			res_side_s <= side_s[NJ-1];
		end
	end

	assign out_valid = res_vld_s;
	assign out_value = res_val_s;
	assign out_side  = res_side_s;

endmodule
`default_nettype wire

### rtl/brsp_div.sv
// Pipelined restoring divider: 62-bit dividend, 32 quotient bits and an overflow flag.
`default_nettype none
module brsp_div #(
	parameter int DW     = 45,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [61:0]       in_num,
	input  logic [DW-1:0]     in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [31:0]       out_quo,
	output logic              out_ovf,
	output logic [SIDE_W-1:0] out_side
);

	localparam int PER = 2;
	localparam int NST = 32 / PER;

	logic              vld_s  [NST+1];
	logic [DW-1:0]     rem_s  [NST+1];
	logic [31:0]       quo_s  [NST+1];
	logic [31:0]       lo_s   [NST+1];
	logic [DW-1:0]     den_s  [NST+1];
	logic              ovf_s  [NST+1];
	logic [SIDE_W-1:0] side_s [NST+1];

	// load the high dividend bits and flag a quotient of 2^32 or more
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= DW'(in_num[61:32]);
			ovf_s[0]  <= DW'(in_num[61:32]) >= in_den;
			quo_s[0]  <= '0;
			lo_s[0]   <= in_num[31:0];
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	genvar k;
	generate
		for (k = 1; k <= NST; k++) begin : g_st
			logic [DW-1:0] rem_c;
			logic [31:0]   quo_c;
			logic [31:0]   lo_c;
			logic [DW:0]   t;

			// two quotient bits
			always_comb begin
				rem_c = rem_s[k-1];
				quo_c = quo_s[k-1];
				lo_c  = lo_s[k-1];
				t     = '0;
				for (int i = 0; i < PER; i++) begin
					t = {rem_c, lo_c[31]};
					lo_c = {lo_c[30:0], 1'b0};
					if (t >= {1'b0, den_s[k-1]}) begin
						rem_c = DW'(t - {1'b0, den_s[k-1]});
						quo_c = {quo_c[30:0], 1'b1};
					end else begin
						rem_c = t[DW-1:0];
						quo_c = {quo_c[30:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[k] <= 1'b0;
				else if (en)
					vld_s[k] <= vld_s[k-1];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= rem_c;
					quo_s[k]  <= quo_c;
					lo_s[k]   <= lo_c;
					den_s[k]  <= den_s[k-1];
					ovf_s[k]  <= ovf_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NST];
	assign out_quo   = quo_s[NST];
	assign out_ovf   = ovf_s[NST];
	assign out_side  = side_s[NST];

endmodule
`default_nettype wire

### rtl/bingham_regularized_stress_point.sv
// Top level of the regularised Bingham stress point: registers, stages and stream ports.
//
//  channel  | dir | beat contents
//  s_*      | in  | s_tdata strain_1..6, s_tuser flow_mode
//  m_*      | out | m_tdata stress_1..6, shear rate, stress magnitude, viscosity
//  APB      | in  | base_viscosity 0x0, yield_stress 0x4, growth_rate 0x8
//
// One beat is taken every cycle while the output is not stalled. Each beat passes through
// two 16-stage square roots, the 31-stage exponential and the 17-stage divider besides
// the stages of this module. A stall at the output freezes every stage at once, so
// nothing is lost or repeated. Reset clears the valid bits and the registers
// (growth_rate resets to 1.0).
`default_nettype none
module bingham_regularized_stress_point import brsp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,  // strain_1 [31:0] .. strain_6 [191:160]
	input  logic [1:0]   s_tuser,  // flow_mode [1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [287:0] m_tdata   // stress_1..6 [191:0], shear_rate_magnitude [222:192],
	                               // stress_magnitude [253:223], effective_viscosity [284:254]
);

	localparam int DW  = 61 - FRAC_BITS;
	localparam int DSH = 30 - FRAC_BITS;
	localparam int BW  = 32 * NLANE + 1;

	logic        en;
	logic [30:0] base_visc_q, yield_q, growth_q;

	// configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_visc_q <= '0;
			yield_q     <= '0;
			growth_q    <= 31'(1) << FRAC_BITS;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_BASE_VISC: base_visc_q <= pwdata[30:0];
				REG_YIELD:     yield_q     <= pwdata[30:0];
				REG_GROWTH:    growth_q    <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_BASE_VISC: prdata = {1'b0, base_visc_q};
			REG_YIELD:     prdata = {1'b0, yield_q};
			REG_GROWTH:    prdata = {1'b0, growth_q};
			default:       prdata = '0;
		endcase
	end

	// every stage advances unless the output holds a beat not yet taken
	logic v_s12;
	assign en       = !v_s12 || m_tready;
	assign s_tready = en;

	// stage 1: register the beat, drop lanes the mode does not use
	logic        v_s1, plane_s1;
	logic [31:0] raw_s1 [NLANE];
	logic        use_c [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			case (s_tuser)
				MODE_PLANE:  use_c[i] = (i < 3);
				MODE_AXISYM: use_c[i] = (i < 4);
				default:     use_c[i] = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plane_s1 <= (s_tuser == MODE_PLANE);
			for (int i = 0; i < NLANE; i++)
				raw_s1[i] <= use_c[i] ? s_tdata[32*i +: 32] : '0;
		end
	end

	// stage 2: strain squares
	logic        v_s2, plane_s2;
	logic [31:0] raw_s2 [NLANE];
	logic [62:0] sq_s2 [NLANE];
	logic [63:0] sq_c [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++)
			sq_c[i] = {32'b0, mag32(raw_s1[i])} * {32'b0, mag32(raw_s1[i])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plane_s2 <= plane_s1;
			for (int i = 0; i < NLANE; i++) begin
				raw_s2[i] <= raw_s1[i];
				sq_s2[i]  <= sq_c[i][62:0];
			end
		end
	end

	// stage 3: weighted sum of squares, saturated to 64 bits
	logic          v_s3;
	logic [63:0]   g2_s3;
	logic [BW-1:0] base_s3;
	logic [64:0]   pair_c, nsum_c;
	logic [65:0]   tot_c;

	always_comb begin
		pair_c = 65'(sq_s2[0]) + 65'(sq_s2[1]);
		nsum_c = pair_c + 65'(sq_s2[2]);
		if (plane_s2)
			tot_c = 66'(pair_c[64:1]) + 66'(sq_s2[2]);
		else
			tot_c = {nsum_c, 1'b0} + 66'(sq_s2[3]) + 66'(sq_s2[4]) + 66'(sq_s2[5]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g2_s3 <= (|tot_c[65:64]) ? '1 : tot_c[63:0];
			for (int i = 0; i < NLANE; i++)
				base_s3[32*i +: 32] <= raw_s2[i];
			base_s3[BW-1] <= plane_s2;
		end
	end

	// shear rate magnitude
	logic          v_q1;
	logic [31:0]   root1;
	logic [BW-1:0] base_q1;

	brsp_sqrt #(.SIDE_W(BW)) u_sqrt_gamma (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.in_rad   (g2_s3),
		.in_side  (base_s3),
		.out_valid(v_q1),
		.out_root (root1),
		.out_side (base_q1)
	);

	// stage 4: saturate gamma, floor it at one LSB, multiply by the growth rate
	logic          v_s4;
	logic [30:0]   gam_s4, g_s4;
	logic [61:0]   mg_s4;
	logic [BW-1:0] base_s4;
	logic [30:0]   gam_c, g_c;

	always_comb begin
		gam_c = root1[31] ? MAX31 : root1[30:0];
		g_c   = (gam_c == '0) ? 31'd1 : gam_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (en)
			v_s4 <= v_q1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gam_s4  <= gam_c;
			g_s4    <= g_c;
			mg_s4   <= {31'b0, growth_q} * {31'b0, g_c};
			base_s4 <= base_q1;
		end
	end

	// stage 5: scale the exponent to base two and split it
	logic                   v_s5, zero_s5;
	logic [4:0]             n_s5;
	logic [29:0]            frac_s5;
	logic [30:0]            gam_s5, g_s5;
	logic [BW-1:0]          base_s5;
	logic [FRAC_BITS+36:0]  y_c;
	logic [6:0]             n_c;
	logic                   big_c;

	always_comb begin
		big_c = |mg_s4[61:2*FRAC_BITS+6];
		y_c   = (FRAC_BITS+37)'(mg_s4[2*FRAC_BITS+5:FRAC_BITS]) *
		        (FRAC_BITS+37)'(LOG2E_Q30);
		n_c   = y_c[FRAC_BITS+36:FRAC_BITS+30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s5 <= big_c || (n_c >= 7'd31);
			n_s5    <= n_c[4:0];
			frac_s5 <= y_c[FRAC_BITS+29:FRAC_BITS];
			gam_s5  <= gam_s4;
			g_s5    <= g_s4;
			base_s5 <= base_s4;
		end
	end

	// exp(-m*g) in Q2.30
	logic                v_q2;
	logic [30:0]         e_q2;
	logic [BW+61:0]      xside_in, xside_out;

	assign xside_in = {g_s5, gam_s5, base_s5};

	brsp_exp #(.SIDE_W(BW + 62)) u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s5),
		.in_zero  (zero_s5),
		.in_shift (n_s5),
		.in_frac  (frac_s5),
		.in_side  (xside_in),
		.out_valid(v_q2),
		.out_value(e_q2),
		.out_side (xside_out)
	);

	// stage 6: numerator tau0*(1-e) and divisor g aligned to Q30
	logic            v_s6;
	logic [61:0]     num_s6;
	logic [DW-1:0]   den_s6;
	logic [BW+30:0]  dside_s6;
	logic [30:0]     onem_c;

	assign onem_c = ONE_Q30 - e_q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_q2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6   <= {31'b0, yield_q} * {31'b0, onem_c};
			den_s6   <= DW'(xside_out[BW+61:BW+31]) << DSH;
			dside_s6 <= xside_out[BW+30:0];
		end
	end

	// yield term quotient
	logic           v_q3, ovf_q3;
	logic [31:0]    quo_q3;
	logic [BW+30:0] dside_q3;

	brsp_div #(.DW(DW), .SIDE_W(BW + 31)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.in_num   (num_s6),
		.in_den   (den_s6),
		.in_side  (dside_s6),
		.out_valid(v_q3),
		.out_quo  (quo_q3),
		.out_ovf  (ovf_q3),
		.out_side (dside_q3)
	);

	// stage 7: effective viscosity, saturated
	logic        v_s7, plane_s7;
	logic [30:0] mu_s7, gam_s7;
	logic [31:0] raw_s7 [NLANE];
	logic [32:0] musum_c;
	logic [30:0] mu_c;

	always_comb begin
		musum_c = 33'(base_visc_q) + 33'(quo_q3);
		if (yield_q == '0)
			mu_c = base_visc_q;
		else if (ovf_q3 || (musum_c > 33'(MAX31)))
			mu_c = MAX31;
		else
			mu_c = musum_c[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (en)
			v_s7 <= v_q3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu_s7    <= mu_c;
			gam_s7   <= dside_q3[BW+30:BW];
			plane_s7 <= dside_q3[BW-1];
			for (int i = 0; i < NLANE; i++)
				raw_s7[i] <= dside_q3[32*i +: 32];
		end
	end

	// stage 8: viscosity times strain magnitude, doubled on normal lanes
	logic        v_s8, plane_s8;
	logic [30:0] mu_s8, gam_s8;
	logic [63:0] prod_s8 [NLANE];
	logic        neg_s8 [NLANE];
	logic [63:0] p_c [NLANE];
	logic        nrm_c [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			nrm_c[i] = (i < 2) || ((i == 2) && !plane_s7);
			p_c[i]   = {33'b0, mu_s7} * {32'b0, mag32(raw_s7[i])};
			if (nrm_c[i])
				p_c[i] = {p_c[i][62:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else if (en)
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu_s8    <= mu_s7;
			gam_s8   <= gam_s7;
			plane_s8 <= plane_s7;
			for (int i = 0; i < NLANE; i++) begin
				prod_s8[i] <= p_c[i];
				neg_s8[i]  <= raw_s7[i][31];
			end
		end
	end

	// stage 9: truncate, apply the sign, saturate
	logic        v_s9, plane_s9;
	logic [30:0] mu_s9, gam_s9;
	logic [31:0] str_s9 [NLANE];
	logic [63:0] psh_c [NLANE];
	logic [31:0] str_c [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			psh_c[i] = prod_s8[i] >> FRAC_BITS;
			if (neg_s8[i])
				str_c[i] = (psh_c[i] > 64'h8000_0000) ? 32'h8000_0000 : 32'(-psh_c[i][31:0]);
			else
				str_c[i] = (psh_c[i] > 64'(MAX31)) ? {1'b0, MAX31} : psh_c[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s9 <= 1'b0;
		else if (en)
			v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu_s9    <= mu_s8;
			gam_s9   <= gam_s8;
			plane_s9 <= plane_s8;
			for (int i = 0; i < NLANE; i++)
				str_s9[i] <= str_c[i];
		end
	end

	// stage 10: stress squares
	logic        v_s10, plane_s10;
	logic [30:0] mu_s10, gam_s10;
	logic [31:0] str_s10 [NLANE];
	logic [62:0] ssq_s10 [NLANE];
	logic [63:0] ssq_c [NLANE];

	always_comb begin
		for (int i = 0; i < NLANE; i++)
			ssq_c[i] = {32'b0, mag32(str_s9[i])} * {32'b0, mag32(str_s9[i])};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s10 <= 1'b0;
		else if (en)
			v_s10 <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mu_s10    <= mu_s9;
			gam_s10   <= gam_s9;
			plane_s10 <= plane_s9;
			for (int i = 0; i < NLANE; i++) begin
				str_s10[i] <= str_s9[i];
				ssq_s10[i] <= ssq_c[i][62:0];
			end
		end
	end

	// stage 11: half the saturated normal sum plus the saturated shear sum
	logic           v_s11;
	logic [63:0]    tau2_s11;
	logic [BW+60:0] tside_s11;
	logic [64:0]    nraw_c, sraw_c, t_c;
	logic [63:0]    nc_c, sc_c;

	always_comb begin
		if (plane_s10) begin
			nraw_c = 65'(ssq_s10[0]) + 65'(ssq_s10[1]);
			sraw_c = 65'(ssq_s10[2]);
		end else begin
			nraw_c = 65'(ssq_s10[0]) + 65'(ssq_s10[1]) + 65'(ssq_s10[2]);
			sraw_c = 65'(ssq_s10[3]) + 65'(ssq_s10[4]) + 65'(ssq_s10[5]);
		end
		nc_c = nraw_c[64] ? '1 : nraw_c[63:0];
		sc_c = sraw_c[64] ? '1 : sraw_c[63:0];
		t_c  = 65'(nc_c[63:1]) + 65'(sc_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s11 <= 1'b0;
		else if (en)
			v_s11 <= v_s10;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tau2_s11 <= t_c[64] ? '1 : t_c[63:0];
			for (int i = 0; i < NLANE; i++)
				tside_s11[32*i +: 32] <= str_s10[i];
			tside_s11[BW+29:BW-1] <= gam_s10;
			tside_s11[BW+60:BW+30] <= mu_s10;
		end
	end

	// stress magnitude
	logic           v_q4;
	logic [31:0]    root2;
	logic [BW+60:0] tside_q4;

	brsp_sqrt #(.SIDE_W(BW + 61)) u_sqrt_tau (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s11),
		.in_rad   (tau2_s11),
		.in_side  (tside_s11),
		.out_valid(v_q4),
		.out_root (root2),
		.out_side (tside_q4)
	);

	// stage 12: output register
	logic [287:0] out_s12;
	logic [30:0]  tau_c;

	assign tau_c = root2[31] ? MAX31 : root2[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s12 <= 1'b0;
		else if (en)
			v_s12 <= v_q4;
	end

	always_ff @(posedge clk) begin
		if (en)
			out_s12 <= {3'b000, tside_q4[BW+60:BW+30], tau_c, tside_q4[BW+29:0]};
	end

	assign m_tvalid = v_s12;
	assign m_tdata  = out_s12;

endmodule
`default_nettype wire

### verif/tb_top.sv
// Self-checking bench for the regularised Bingham stress point: streamed strains against a local model.
`default_nettype none
module tb_top;
	import brsp_pkg::*;

	localparam logic [1:0]  REG_SPARE  = 2'd3;   // unmapped index, writes are dropped
	localparam logic [1:0]  MODE_SPATIAL = 2'd2;
	localparam logic [1:0]  MODE_SPARE   = 2'd3; // undefined code, behaves as spatial flow
	localparam logic [63:0] ONE_Q30_64 = 64'd1 << 30;
	localparam logic [63:0] ALL64      = '1;
	localparam int          RAND_ITEMS = 160;
	localparam int          SETTLE     = 120;

	// first member sits in the top bits: viscosity, magnitude, shear rate, then stresses
	typedef struct packed {
		logic [30:0]      mu;
		logic [30:0]      tau;
		logic [30:0]      gamma;
		logic [5:0][31:0] stress;
	} point_res_t;

	typedef struct {
		logic [1:0]       mode;
		logic [5:0][31:0] strain;
		bit               known;
		point_res_t       res;
	} vec_t;

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_tvalid, s_tready;
	logic [191:0] s_tdata;   // strain_1 [31:0] .. strain_6 [191:160]
	logic [1:0]   s_tuser;   // flow_mode [1:0]
	logic         m_tvalid, m_tready;
	logic [287:0] m_tdata;   // stress_1..6 [191:0], gamma [222:192], tau [253:223], mu [284:254]

	// local copy of the registers
	logic [30:0] base_visc, yield_str, growth;
	logic [63:0] exp_coef [1:30];

	point_res_t  stress_due [$];
	int          errors, results_seen, items_sent, burst_left;

	bingham_regularized_stress_point uut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	// ---------------- model ----------------
	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? ALL64 : s[63:0];
	endfunction

	function automatic logic [63:0] clip31(input logic [63:0] v);
		return (v > 64'(MAX31)) ? 64'(MAX31) : v;
	endfunction

	function automatic logic [63:0] abs32(input logic [31:0] r);
		return r[31] ? (64'd1 << 32) - 64'(r) : 64'(r);
	endfunction

	// 2^(-x*log2 e) in Q2.30, x in Q16.16
	function automatic logic [63:0] neg_exp(input logic [63:0] x);
		logic [63:0] y, n, f, acc;
		if ((x >> 16) >= 64) return 0;
		y = x * 64'(LOG2E_Q30);
		n = y >> 46;
		if (n >= 31) return 0;
		f = (y >> 16) & (ONE_Q30_64 - 1);
		acc = ONE_Q30_64;
		for (int j = 1; j <= 30; j++)
			if (f[30 - j]) acc = (acc * exp_coef[j] + (64'd1 << 29)) >> 30;
		return acc >> n;
	endfunction

	function automatic logic [63:0] visc_of(input logic [63:0] gam);
		logic [63:0] g, e, q;
		if (yield_str == 0) return 64'(base_visc);
		g = (gam == 0) ? 64'd1 : gam;
		e = neg_exp((64'(growth) * g) >> 16);
		q = (64'(yield_str) * (ONE_Q30_64 - e)) / (g << 14);
		return clip31(add_sat(64'(base_visc), q));
	endfunction

	function automatic logic [31:0] stress_of(input logic [63:0] mu, input logic [31:0] raw,
			input bit normal);
		logic [63:0] p;
		p = mu * abs32(raw);
		if (normal) p = p << 1;
		p = p >> 16;
		if (raw[31]) begin
			if (p > (64'd1 << 31)) p = 64'd1 << 31;
			return 32'(-p);
		end
		return 32'(clip31(p));
	endfunction

	function automatic point_res_t point_stress(input logic [1:0] mode,
			input logic [5:0][31:0] e);
		point_res_t  r;
		logic [63:0] nsum, ssum, g2, gam, mu, m;
		int          nn, ns;
		nsum = 0;
		ssum = 0;
		r = '0;
		if (mode == MODE_PLANE) begin
			nn = 2; ns = 1;
		end else if (mode == MODE_AXISYM) begin
			nn = 3; ns = 1;
		end else begin
			nn = 3; ns = 3;
		end
		for (int i = 0; i < nn; i++) nsum = add_sat(nsum, abs32(e[i]) * abs32(e[i]));
		for (int i = nn; i < nn + ns; i++) ssum = add_sat(ssum, abs32(e[i]) * abs32(e[i]));
		g2 = (mode == MODE_PLANE) ? add_sat(nsum >> 1, ssum) : add_sat(add_sat(nsum, nsum), ssum);
		gam = clip31(root64(g2));
		mu = visc_of(gam);
		for (int i = 0; i < nn + ns; i++) r.stress[i] = stress_of(mu, e[i], i < nn);
		nsum = 0;
		ssum = 0;
		for (int i = 0; i < nn; i++) begin
			m = abs32(r.stress[i]);
			nsum = add_sat(nsum, m * m);
		end
		for (int i = nn; i < nn + ns; i++) begin
			m = abs32(r.stress[i]);
			ssum = add_sat(ssum, m * m);
		end
		r.gamma = 31'(gam);
		r.tau = 31'(clip31(root64(add_sat(nsum >> 1, ssum))));
		r.mu = 31'(mu);
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [31:0] rand_strain();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3, 4, 5: return $urandom;
			default: begin
				logic [31:0] v;
				v = $urandom_range(0, 32'h0010_0000);
				return $urandom_range(0, 1) ? -v : v;
			end
		endcase
	endfunction

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_BASE_VISC: base_visc = val[30:0];
			REG_YIELD:     yield_str = val[30:0];
			REG_GROWTH:    growth    = val[30:0];
			default: ;
		endcase
	endtask

	// wait until the pipe has drained, then let it settle
	task automatic drain();
		while (stress_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [31:0] mu0, input logic [31:0] tau0,
			input logic [31:0] m);
		drain();
		reg_write(REG_BASE_VISC, mu0);
		reg_write(REG_YIELD, tau0);
		reg_write(REG_GROWTH, m);
		reg_write(REG_SPARE, $urandom);
	endtask

	// present one beat at a falling edge, hold until taken; bursts with random gaps
	task automatic send_point(input vec_t v);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tuser = v.mode;
		s_tdata = v.strain;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		stress_due.push_back(v.known ? v.res : point_stress(v.mode, v.strain));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		vec_t v;
		for (int k = 0; k < count; k++) begin
			v.mode = 2'($urandom_range(0, 3));
			for (int i = 0; i < 6; i++) v.strain[i] = rand_strain();
			v.known = 0;
			send_point(v);
		end
		s_tvalid = 1'b0;
	endtask

	// ---------------- directed vectors ----------------
	vec_t vectors [$];

	task automatic add_vec(input logic [1:0] mode, input logic [5:0][31:0] e, input bit known,
			input point_res_t res);
		vec_t v;
		v.mode = mode;
		v.strain = e;
		v.known = known;
		v.res = res;
		vectors.push_back(v);
	endtask

	task automatic send_vectors(input bit use_known);
		vec_t v;
		foreach (vectors[i]) begin
			v = vectors[i];
			v.known = v.known && use_known;
			send_point(v);
		end
		s_tvalid = 1'b0;
	endtask

	// ---------------- receiver stall pattern ----------------
	int stall_mode, stall_cnt;
	always @(negedge clk) begin
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_cnt = $urandom_range(16, 96);
		end
		stall_cnt--;
		case (stall_mode)
			0: m_tready = 1'b1;
			1: m_tready = ($urandom_range(0, 3) != 0);
			2: m_tready = ($urandom_range(0, 2) == 0);
			default: m_tready = (stall_cnt % 8) < 5;
		endcase
	end

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		point_res_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = point_res_t'(m_tdata[284:0]);
			results_seen++;
			if (stress_due.size() == 0) begin
				$display("%0t: result with none pending: %h", $time, got);
				errors++;
			end else begin
				want = stress_due.pop_front();
				for (int i = 0; i < 6; i++)
					if (got.stress[i] !== want.stress[i]) begin
						$display("%0t: stress_%0d expected %h got %h", $time, i + 1,
							want.stress[i], got.stress[i]);
						errors++;
					end
				if (got.gamma !== want.gamma) begin
					$display("%0t: shear rate expected %h got %h", $time, want.gamma, got.gamma);
					errors++;
				end
				if (got.tau !== want.tau) begin
					$display("%0t: stress magnitude expected %h got %h", $time, want.tau, got.tau);
					errors++;
				end
				if (got.mu !== want.mu) begin
					$display("%0t: viscosity expected %h got %h", $time, want.mu, got.mu);
					errors++;
				end
			end
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		point_res_t z, r;
		errors = 0; results_seen = 0; items_sent = 0; burst_left = 0;
		stall_cnt = 0; stall_mode = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
		base_visc = '0; yield_str = '0; growth = 31'h0001_0000;
		exp_coef[1] = root64(64'd1 << 59);
		for (int j = 2; j <= 30; j++) exp_coef[j] = root64(exp_coef[j - 1] << 30);

		// zero viscosity at reset: stresses vanish, only the shear rate shows
		z = '0;
		add_vec(MODE_PLANE, '0, 1, z);
		r = z; r.gamma = 31'h1_0000;
		add_vec(MODE_PLANE, {32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0}, 1, r);
		r = z; r.gamma = 31'd113511;
		add_vec(MODE_SPATIAL, {32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h0, 32'h0, 32'h0}, 1, r);
		// strains the mode does not use are ignored
		add_vec(MODE_PLANE, {{3{32'h7fff_ffff}}, 32'h0, 32'h0, 32'h0}, 1, z);
		add_vec(MODE_AXISYM, {{2{32'h8000_0000}}, 32'h0, 32'h0, 32'h0, 32'h0}, 1, z);
		// extremes in every mode, the undefined mode among them
		for (int md = 0; md < 4; md++) begin
			add_vec(2'(md), {6{32'h8000_0000}}, 0, z);
			add_vec(2'(md), {6{32'h7fff_ffff}}, 0, z);
			add_vec(2'(md), {6{32'hffff_ffff}}, 0, z);
			add_vec(2'(md), {6{32'h0000_0001}}, 0, z);
		end
		add_vec(MODE_SPARE, {32'h1234_5678, 32'hfedc_ba98, 32'h0001_8000, 32'hffff_0000,
			32'h0000_4000, 32'h8000_0001}, 0, z);

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_vectors(1);
		// yield stress on: zero shear rate hits the one-LSB floor
		set_regs(32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
		send_vectors(0);
		send_random(RAND_ITEMS);
		// every register at its top, top bit of the write dropped
		set_regs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_random(RAND_ITEMS);
		// zero growth rate leaves only the base viscosity
		set_regs($urandom_range(0, 32'h0004_0000), 32'h0004_0000, 32'h0);
		send_random(RAND_ITEMS);
		set_regs(32'h0, 32'h1, 32'h7fff_ffff);
		send_random(RAND_ITEMS);
		set_regs($urandom_range(0, 32'h0010_0000), $urandom_range(1, 32'h0010_0000),
			$urandom_range(0, 32'h0008_0000));
		send_random(RAND_ITEMS);
		// Newtonian with a non-zero base viscosity
		set_regs(32'h0001_0000, 32'h0, $urandom);
		send_random(RAND_ITEMS);

		drain();
		$display("Sent %0d strain points over seven register settings, %0d results checked,",
			items_sent, results_seen);
		$display("all four flow mode codes with stalls on both streams; %0d mismatches.", errors);
		if (errors == 0 && stress_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
rtl/brsp_pkg.sv
rtl/brsp_sqrt.sv
rtl/brsp_exp.sv
rtl/brsp_div.sv
rtl/bingham_regularized_stress_point.sv
verif/tb_top.sv
